/* hdl/miller_rabin_round_top_macros.svh */
// Assertion macros for the Miller-Rabin round block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef MILLER_RABIN_ROUND_TOP_MACROS_SVH
`define MILLER_RABIN_ROUND_TOP_MACROS_SVH

// same-cycle implication
`define MRR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mrr_pkg.sv */
// Shared types and constants for the Miller-Rabin round block.
// No dependencies.
package mrr_pkg;

    // width of the candidate and witness fields on the ports
    localparam int FIELD_W = 62;

    // status of the shift-and-add modular multiplier
    typedef struct packed {
        logic idle;
        logic done;
    } mrr_mul_stat_t;

endpackage

/* hdl/mrr_in_if.sv */
// Input channel: candidate and witness with valid/ready.
// Depends on mrr_pkg.
interface mrr_in_if;
    import mrr_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] candidate;
    logic [FIELD_W-1:0] witness;

    modport source (output valid, output candidate, output witness, input ready);
    modport sink   (input valid, input candidate, input witness, output ready);
endinterface

/* hdl/mrr_out_if.sv */
// Output channel: round verdict with valid/ready.
// No dependencies.
interface mrr_out_if;
    logic valid;
    logic ready;
    logic passes;

    modport source (output valid, output passes, input ready);
    modport sink   (input valid, input passes, output ready);
endinterface

/* hdl/mrr_mulmod.sv */
// Bit-serial modular multiplier: (x * y) mod m, one multiplier bit a cycle.
// Depends on mrr_pkg. Requires x < m.
module mrr_mulmod #(
    parameter int W = 62
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [W-1:0]           x,
    input  logic [W-1:0]           y,
    input  logic [W-1:0]           m,
    output logic [W-1:0]           product,
    output mrr_pkg::mrr_mul_stat_t stat
);
    import mrr_pkg::*;

    logic         run_reg, run_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] add_reg, add_next;
    logic [W-1:0] y_reg, y_next;
    logic [W:0]   sum;
    logic [W:0]   dbl;
    logic [W:0]   m_ext;
    logic         finish;

    assign m_ext  = {1'b0, m};
    assign sum    = {1'b0, acc_reg} + {1'b0, add_reg};
    assign dbl    = {add_reg, 1'b0};
    assign finish = run_reg && (y_reg == '0);

    always_comb
    begin
        run_next = run_reg;
        acc_next = acc_reg;
        add_next = add_reg;
        y_next   = y_reg;
        if (start)
        begin
            run_next = 1'b1;
            acc_next = '0;
            add_next = x;
            y_next   = y;
        end
        else if (finish)
        begin
            run_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (y_reg[0])
            begin
                acc_next = (sum >= m_ext) ? W'(sum - m_ext) : W'(sum);
            end
            add_next = (dbl >= m_ext) ? W'(dbl - m_ext) : W'(dbl);
            y_next   = y_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        add_reg <= add_next;
        y_reg   <= y_next;
    end

    assign product   = acc_reg;
    assign stat.done = finish;
    assign stat.idle = !run_reg;
endmodule

/* hdl/miller_rabin_round_top.sv */
// Miller-Rabin round: sequencer, operand registers and result register.
// Depends on mrr_pkg, mrr_in_if, mrr_out_if and mrr_mulmod.
//
//  channel | dir | fields                  | transfer
//  --------+-----+-------------------------+------------------------
//  in_ch   | in  | candidate, witness (62) | valid && ready
//  out_ch  | out | passes (1)              | valid && ready
//
// One item at a time. Every modular product runs on the one shift-and-add
// multiplier; a round needs about two products per exponent bit plus up to k
// squarings. Trivial candidates skip the multiplier and go straight to S_FIN.
// Reset is asynchronous, active low; no clearing pass. A new item is taken
// while the previous verdict still waits in the output register.
module miller_rabin_round_top #(
    parameter int NUM_WIDTH = 62
) (
    input  logic      clk,
    input  logic      rst_n,
    mrr_in_if.sink    in_ch,
    mrr_out_if.source out_ch
);
    import mrr_pkg::*;

    localparam int W  = NUM_WIDTH;
    localparam int KW = $clog2(NUM_WIDTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;  // trivial candidates
    localparam logic [3:0] S_SPLIT = 4'd2;  // n-1 = q * 2^k
    localparam logic [3:0] S_RED   = 4'd3;  // witness mod n
    localparam logic [3:0] S_PCHK  = 4'd4;  // next exponent bit
    localparam logic [3:0] S_PMUL  = 4'd5;  // acc * sq
    localparam logic [3:0] S_PSQR  = 4'd6;  // sq * sq
    localparam logic [3:0] S_POST  = 4'd7;  // power == 1 test
    localparam logic [3:0] S_LOOP  = 4'd8;  // n-1 tests over k squarings
    localparam logic [3:0] S_SQR   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10; // hand verdict to output register

    logic [3:0]    state_reg, state_next;
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  q_reg, q_next;
    logic [KW-1:0] k_reg, k_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  sq_reg, sq_next;
    logic          res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_passes_reg, out_passes_next;

    logic          mul_start;
    logic [W-1:0]  mul_x;
    logic [W-1:0]  mul_y;
    logic [W-1:0]  mul_prod;
    mrr_mul_stat_t mul_stat;
    logic [W-1:0]  n_minus_1;
    logic          in_xfer;

    // the shared multiplier; the modulus is n throughout a round
    mrr_mulmod #(
        .W (W)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .m       (n_reg),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    assign n_minus_1   = n_reg - W'(1);
    assign in_ch.ready = (state_reg == S_IDLE) && mul_stat.idle;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        a_next          = a_reg;
        q_next          = q_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        sq_next         = sq_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_passes_next = out_passes_reg;
        mul_start       = 1'b0;
        mul_x           = sq_reg;
        mul_y           = sq_reg;

        // verdict leaves on a transfer; may be refilled in the same cycle below
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next     = in_ch.candidate[W-1:0];
                    a_next     = in_ch.witness[W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (n_reg < W'(2))
                begin
                    res_next   = 1'b0;
                    state_next = S_FIN;
                end
                else if (n_reg == W'(2))
                begin
                    res_next   = 1'b1;
                    state_next = S_FIN;
                end
                else if (!n_reg[0])
                begin
                    res_next   = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    q_next     = n_minus_1;
                    k_next     = '0;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (!q_reg[0])
                begin
                    q_next = q_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    // 1 * a mod n reduces the witness
                    mul_start  = 1'b1;
                    mul_x      = W'(1);
                    mul_y      = a_reg;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                if (mul_stat.done)
                begin
                    sq_next    = mul_prod;
                    acc_next   = W'(1);
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (q_reg == '0)
                begin
                    state_next = S_POST;
                end
                else if (q_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_x      = acc_reg;
                    mul_y      = sq_reg;
                    state_next = S_PMUL;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = S_PSQR;
                end
            end
            S_PMUL:
            begin
                if (mul_stat.done)
                begin
                    acc_next   = mul_prod;
                    mul_start  = 1'b1;
                    state_next = S_PSQR;
                end
            end
            S_PSQR:
            begin
                if (mul_stat.done)
                begin
                    sq_next    = mul_prod;
                    q_next     = q_reg >> 1;
                    state_next = S_PCHK;
                end
            end
            S_POST:
            begin
                if (acc_reg == W'(1))
                begin
                    res_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (k_reg == '0)
                begin
                    res_next   = 1'b0;
                    state_next = S_FIN;
                end
                else if (acc_reg == n_minus_1)
                begin
                    res_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_x      = acc_reg;
                    mul_y      = acc_reg;
                    k_next     = k_reg - KW'(1);
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                if (mul_stat.done)
                begin
                    acc_next   = mul_prod;
                    state_next = S_LOOP;
                end
            end
            S_FIN:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_passes_next = res_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        a_reg          <= a_next;
        q_reg          <= q_next;
        k_reg          <= k_next;
        acc_reg        <= acc_next;
        sq_reg         <= sq_next;
        res_reg        <= res_next;
        out_passes_reg <= out_passes_next;
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.passes = out_passes_reg;
endmodule

/* hdl/mrr_checker.sv */
// Port-level checks for the Miller-Rabin round block, bound to the top level.
// Depends on miller_rabin_round_top_macros.svh.
`include "miller_rabin_round_top_macros.svh"

module mrr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_passes
);
    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] pend_reg, pend_next;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // items taken but whose verdict has not left yet
    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!in_xfer && out_xfer)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `MRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_passes), "verdict dropped or changed while stalled")
    `MRR_ASSERT_NEXT(a_busy_after_take, in_xfer, !in_ready, "input taken again right after a transfer")
    `MRR_ASSERT_NOW(a_no_phantom, out_valid, pend_reg != 2'd0, "verdict without a pending item")
    `MRR_ASSERT_NOW(a_depth, in_xfer, pend_reg != 2'd2, "input taken with two items outstanding")
endmodule

bind miller_rabin_round_top mrr_checker u_mrr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_passes (out_ch.passes)
);
